/* rtl/core/vcfh_pkg.sv */
// Package: shared types and constants for the channel frame handler.
`timescale 1ns / 1ps
`default_nettype none
package vcfh_pkg;

    localparam int FRAME_BYTES  = 8;
    localparam int CNT_W        = $clog2(FRAME_BYTES);
    localparam int BUF_DEPTH    = FRAME_BYTES - 1;
    localparam int BUF_IDX_W    = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
    localparam int FIELD_SLOTS  = 7;
    localparam int REPLY_LEN    = 8;
    localparam int PHASE_W      = $clog2(REPLY_LEN + 1);
    localparam int REPLY_IDX_W  = $clog2(REPLY_LEN);
    localparam int JOBQ_DEPTH   = 2;
    localparam int JOBQ_PTR_W   = 1;
    localparam int JOBQ_CNT_W   = 2;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 8;

    localparam logic [7:0] HEADER_RST   = 8'hED;
    localparam logic [7:0] TIMEOUT_RST  = 8'd20;
    localparam logic [7:0] DISPENSE_RST = 8'h70;
    localparam logic [7:0] STATUS_RST   = 8'h00;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HEADER   = 2'd0,
        CFG_TIMEOUT  = 2'd1,
        CFG_DISPENSE = 2'd2,
        CFG_STATUS   = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        VERDICT_DISPENSE = 2'd0,
        VERDICT_CHECK    = 2'd1,
        VERDICT_ERROR    = 2'd2
    } t_verdict;

    typedef enum logic {
        KIND_VERDICT = 1'b0,
        KIND_REPLY   = 1'b1
    } t_kind;

    typedef enum logic {
        OP_BYTE = 1'b0,
        OP_TICK = 1'b1
    } t_op;

    typedef struct packed {
        logic       operation;
        logic [7:0] rx_byte;
    } t_in_item;

    typedef struct packed {
        logic       kind;
        logic [1:0] verdict;
        logic [7:0] frame_length;
        logic [7:0] sequence_res;
        logic [7:0] msg_type;
        logic [7:0] column;
        logic [7:0] data_one;
        logic [7:0] data_two;
        logic [7:0] reply_byte;
        logic       last;
    } t_out_item;

    typedef struct packed {
        logic [7:0] header_byte;
        logic [7:0] timeout_ticks;
        logic [7:0] dispense_code;
        logic [7:0] reply_status;
    } t_cfg;

    typedef struct packed {
        t_verdict   verdict;
        logic [7:0] frame_length;
        logic [7:0] sequence_res;
        logic [7:0] msg_type;
        logic [7:0] column;
        logic [7:0] data_one;
        logic [7:0] data_two;
    } t_job;

endpackage
`default_nettype wire

/* rtl/core/vcfh_front.sv */
// Front end: frame assembly, timeout, frame check and classification into jobs.
`timescale 1ns / 1ps
`default_nettype none
module vcfh_front (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_accept,
    input  vcfh_pkg::t_in_item  i_item,
    input  vcfh_pkg::t_cfg      i_cfg,
    output logic                o_job_push,
    output vcfh_pkg::t_job      o_job
);
    import vcfh_pkg::*;

    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [7:0]       r_tleft, n_tleft;
    logic [7:0]       r_xor, n_xor;
    logic [7:0]       r_buf [BUF_DEPTH];
    logic [7:0]       r_len, r_seq, r_type, r_col, r_d1, r_d2;
    logic [7:0]       n_len, n_seq, n_type, n_col, n_d1, n_d2;
    logic             w_buf_we;
    logic [7:0]       w_fld [FIELD_SLOTS];

    // positions at or past the check byte read as zero
    for (genvar gi = 0; gi < FIELD_SLOTS; gi++) begin : g_fld
        if (gi < BUF_DEPTH) begin : g_real
            assign w_fld[gi] = r_buf[gi];
        end else begin : g_zero
            assign w_fld[gi] = 8'h00;
        end
    end

    always_comb begin
        n_cnt      = r_cnt;
        n_tleft    = r_tleft;
        n_xor      = r_xor;
        n_len      = r_len;
        n_seq      = r_seq;
        n_type     = r_type;
        n_col      = r_col;
        n_d1       = r_d1;
        n_d2       = r_d2;
        w_buf_we   = 1'b0;
        o_job_push = 1'b0;
        o_job.verdict = VERDICT_ERROR;
        if (i_accept) begin
            if (i_item.operation == OP_TICK) begin
                if (r_cnt != '0) begin
                    if (r_tleft <= 8'd1) begin
                        n_tleft    = 8'd0;
                        n_cnt      = '0;
                        o_job_push = 1'b1;
                    end else begin
                        n_tleft = r_tleft - 8'd1;
                    end
                end
            end else if (r_cnt == CNT_W'(FRAME_BYTES - 1)) begin
                n_cnt      = '0;
                n_tleft    = 8'd0;
                o_job_push = 1'b1;
                if (w_fld[0] != i_cfg.header_byte || r_xor != i_item.rx_byte) begin
                    o_job.verdict = VERDICT_ERROR;
                end else if (r_seq != 8'd0 && r_seq == w_fld[2]) begin
                    o_job.verdict = VERDICT_CHECK;
                end else begin
                    n_len  = w_fld[1];
                    n_seq  = w_fld[2];
                    n_type = w_fld[3];
                    n_col  = w_fld[4];
                    n_d1   = w_fld[5];
                    n_d2   = w_fld[6];
                    o_job.verdict = (w_fld[3] == i_cfg.dispense_code) ?
                                    VERDICT_DISPENSE : VERDICT_CHECK;
                end
            end else begin
                w_buf_we = 1'b1;
                n_cnt    = r_cnt + CNT_W'(1);
                if (r_cnt == '0) begin
                    n_tleft = i_cfg.timeout_ticks;
                    n_xor   = i_item.rx_byte;
                end else begin
                    n_xor   = r_xor ^ i_item.rx_byte;
                end
            end
        end
        o_job.frame_length = n_len;
        o_job.sequence_res = n_seq;
        o_job.msg_type     = n_type;
        o_job.column       = n_col;
        o_job.data_one     = n_d1;
        o_job.data_two     = n_d2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_tleft <= 8'd0;
            r_len   <= 8'd0;
            r_seq   <= 8'd0;
            r_type  <= 8'd0;
            r_col   <= 8'd0;
            r_d1    <= 8'd0;
            r_d2    <= 8'd0;
        end else begin
            r_cnt   <= n_cnt;
            r_tleft <= n_tleft;
            r_len   <= n_len;
            r_seq   <= n_seq;
            r_type  <= n_type;
            r_col   <= n_col;
            r_d1    <= n_d1;
            r_d2    <= n_d2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_xor <= n_xor;
        if (w_buf_we) begin
            r_buf[r_cnt[BUF_IDX_W-1:0]] <= i_item.rx_byte;
        end
    end

endmodule
`default_nettype wire

/* rtl/core/vcfh_job_queue.sv */
// Short job queue between front end and result sequencer.
`timescale 1ns / 1ps
`default_nettype none
module vcfh_job_queue (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_push,
    input  vcfh_pkg::t_job  i_job,
    input  wire             i_pop,
    output logic            o_full,
    output logic            o_valid,
    output vcfh_pkg::t_job  o_job
);
    import vcfh_pkg::*;

    t_job                  r_mem [JOBQ_DEPTH];
    logic [JOBQ_PTR_W-1:0] r_wr, r_rd;
    logic [JOBQ_CNT_W-1:0] r_count;
    logic                  w_do_push, w_do_pop;

    assign o_full    = (r_count == JOBQ_CNT_W'(JOBQ_DEPTH));
    assign o_valid   = (r_count != '0);
    assign o_job     = r_mem[r_rd];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (w_do_push) r_wr <= r_wr + JOBQ_PTR_W'(1);
            if (w_do_pop)  r_rd <= r_rd + JOBQ_PTR_W'(1);
            r_count <= r_count + JOBQ_CNT_W'(w_do_push) - JOBQ_CNT_W'(w_do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

endmodule
`default_nettype wire

/* rtl/core/vcfh_back.sv */
// Back end: expands each job into verdict and reply items into an output register.
`timescale 1ns / 1ps
`default_nettype none
module vcfh_back (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_job_valid,
    input  vcfh_pkg::t_job      i_job,
    input  vcfh_pkg::t_cfg      i_cfg,
    output logic                o_job_pop,
    input  wire                 i_pop,
    output logic                o_empty,
    output vcfh_pkg::t_out_item o_out_item
);
    import vcfh_pkg::*;

    logic [PHASE_W-1:0]     r_phase, n_phase;
    logic                   r_valid;
    t_out_item              r_item, n_item;
    logic                   w_adv, w_load;
    logic [7:0]             w_reply [REPLY_LEN];
    logic [PHASE_W-1:0]     w_ridx_full;
    logic [REPLY_IDX_W-1:0] w_ridx;

    assign w_adv   = !r_valid || i_pop;
    assign w_load  = w_adv && i_job_valid;
    assign o_empty = !r_valid;
    assign o_out_item = r_item;

    assign w_reply[0] = i_cfg.header_byte + 8'd1;
    assign w_reply[1] = i_cfg.reply_status;
    assign w_reply[2] = i_job.sequence_res;
    assign w_reply[3] = i_job.msg_type;
    assign w_reply[4] = i_job.column;
    assign w_reply[5] = 8'h00;
    assign w_reply[6] = 8'h00;
    assign w_reply[7] = w_reply[0] ^ w_reply[1] ^ w_reply[2] ^ w_reply[3] ^ w_reply[4];

    assign w_ridx_full = r_phase - PHASE_W'(1);
    assign w_ridx      = w_ridx_full[REPLY_IDX_W-1:0];

    always_comb begin
        n_phase   = r_phase;
        o_job_pop = 1'b0;
        n_item.frame_length = i_job.frame_length;
        n_item.sequence_res = i_job.sequence_res;
        n_item.msg_type     = i_job.msg_type;
        n_item.column       = i_job.column;
        n_item.data_one     = i_job.data_one;
        n_item.data_two     = i_job.data_two;
        if (r_phase == '0) begin
            n_item.kind       = KIND_VERDICT;
            n_item.verdict    = i_job.verdict;
            n_item.reply_byte = 8'h00;
            n_item.last       = (i_job.verdict != VERDICT_CHECK);
        end else begin
            n_item.kind       = KIND_REPLY;
            n_item.verdict    = VERDICT_CHECK;
            n_item.reply_byte = w_reply[w_ridx];
            n_item.last       = (r_phase == PHASE_W'(REPLY_LEN));
        end
        if (w_load) begin
            if (n_item.last) begin
                o_job_pop = 1'b1;
                n_phase   = '0;
            end else begin
                n_phase   = r_phase + PHASE_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
            r_valid <= 1'b0;
        end else begin
            r_phase <= n_phase;
            if (w_adv) r_valid <= i_job_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) r_item <= n_item;
    end

endmodule
`default_nettype wire

/* rtl/core/vend_channel_frame_handler_core.sv */
// Top level: configuration registers and front/queue/back hookup.
//
//  channel   handshake              payload
//  input     push / full            i_in_item  (t_in_item)
//  result    empty / pop            o_out_item (t_out_item)
//  config    i_cfg_we               i_cfg_idx, i_cfg_data
//
// Input transfers are taken one per cycle while the two-entry job queue has room.
// A finished frame yields one result item (dispense, error) or nine (check),
// sent one per cycle while pop is held, from the output register; the back end sets this rate.
// A result passes through the job queue and then the output register before it appears.
// Reset is synchronous; a stalled result side fills the queue and raises full.
`timescale 1ns / 1ps
`default_nettype none
module vend_channel_frame_handler_core (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                push,
    output logic                               full,
    input  vcfh_pkg::t_in_item                 i_in_item,
    output logic                               empty,
    input  wire                                pop,
    output vcfh_pkg::t_out_item                o_out_item,
    input  wire                                i_cfg_we,
    input  wire  [vcfh_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire  [vcfh_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import vcfh_pkg::*;

    t_cfg r_cfg;
    t_job w_front_job, w_q_job;
    logic w_front_push, w_q_valid, w_q_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.header_byte   <= HEADER_RST;
            r_cfg.timeout_ticks <= TIMEOUT_RST;
            r_cfg.dispense_code <= DISPENSE_RST;
            r_cfg.reply_status  <= STATUS_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_HEADER:   r_cfg.header_byte   <= i_cfg_data;
                CFG_TIMEOUT:  r_cfg.timeout_ticks <= i_cfg_data;
                CFG_DISPENSE: r_cfg.dispense_code <= i_cfg_data;
                CFG_STATUS:   r_cfg.reply_status  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    vcfh_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (push && !full),
        .i_item     (i_in_item),
        .i_cfg      (r_cfg),
        .o_job_push (w_front_push),
        .o_job      (w_front_job)
    );

    vcfh_job_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_front_push),
        .i_job   (w_front_job),
        .i_pop   (w_q_pop),
        .o_full  (full),
        .o_valid (w_q_valid),
        .o_job   (w_q_job)
    );

    vcfh_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (w_q_valid),
        .i_job       (w_q_job),
        .i_cfg       (r_cfg),
        .o_job_pop   (w_q_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_out_item  (o_out_item)
    );

endmodule
`default_nettype wire

/* dv/vend_channel_frame_handler_core_tb.sv */
// Testbench for the channel frame handler core: random link traffic checked against a local predictor.
`timescale 1ns / 1ps
module vend_channel_frame_handler_core_tb;
    import vcfh_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 400;
    localparam int SETTLE      = 10;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  push = 1'b0;
    logic                  full;
    t_in_item              i_in_item = '0;
    logic                  empty;
    logic                  pop = 1'b0;
    t_out_item             o_out_item;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    vend_channel_frame_handler_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_in_item  (i_in_item),
        .empty      (empty),
        .pop        (pop),
        .o_out_item (o_out_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // register copies, as last written
    logic [7:0] hdr_reg      = HEADER_RST;
    logic [7:0] timeout_reg  = TIMEOUT_RST;
    logic [7:0] dispense_reg = DISPENSE_RST;
    logic [7:0] status_reg   = STATUS_RST;

    // frame handler state as the block should hold it
    logic [7:0] frame_bytes [0:FRAME_BYTES-1];
    int         rx_count   = 0;
    logic [7:0] ticks_left = '0;
    logic [7:0] keep_len   = '0;
    logic [7:0] keep_seq   = '0;
    logic [7:0] keep_type  = '0;
    logic [7:0] keep_col   = '0;
    logic [7:0] keep_d1    = '0;
    logic [7:0] keep_d2    = '0;

    t_in_item  link_bytes [$];   // bytes and ticks waiting to go out
    t_out_item owed [$];         // results the block still owes, oldest first

    int  cycles      = 0;
    int  errors      = 0;
    int  checked     = 0;
    int  item_total  = 0;
    int  mix_items   = 0;
    int  settings    = 1;
    int  full_stalls = 0;
    int  n_disp      = 0;
    int  n_chk       = 0;
    int  n_err       = 0;
    bit  steady      = 1'b0;
    bit  hold_armed  = 1'b0;
    bit  hold_done   = 1'b0;
    int  hold_cnt    = 0;
    logic [7:0] gen_seq = '0;

    function automatic t_out_item frame_result(input t_kind k, input t_verdict v,
                                               input logic [7:0] rb, input logic lst);
        t_out_item o;
        o.kind         = k;
        o.verdict      = v;
        o.frame_length = keep_len;
        o.sequence_res = keep_seq;
        o.msg_type     = keep_type;
        o.column       = keep_col;
        o.data_one     = keep_d1;
        o.data_two     = keep_d2;
        o.reply_byte   = rb;
        o.last         = lst;
        return o;
    endfunction

    // positions at or past the check byte read as zero
    function automatic logic [7:0] frame_field(input int pos);
        if (pos + 1 < FRAME_BYTES) return frame_bytes[pos];
        return 8'h00;
    endfunction

    task automatic owe_reply();
        logic [7:0] r [0:REPLY_LEN-1];
        logic [7:0] x;
        int         i;
        r[0] = hdr_reg + 8'd1;
        r[1] = status_reg;
        r[2] = keep_seq;
        r[3] = keep_type;
        r[4] = keep_col;
        r[5] = 8'h00;
        r[6] = 8'h00;
        x = '0;
        for (i = 0; i < REPLY_LEN - 1; i++) x ^= r[i];
        r[REPLY_LEN-1] = x;
        n_chk++;
        owed.push_back(frame_result(KIND_VERDICT, VERDICT_CHECK, 8'h00, 1'b0));
        for (i = 0; i < REPLY_LEN; i++)
            owed.push_back(frame_result(KIND_REPLY, VERDICT_CHECK, r[i], i == REPLY_LEN - 1));
    endtask

    task automatic close_frame();
        logic [7:0] x;
        int         i;
        x = '0;
        for (i = 0; i < FRAME_BYTES - 1; i++) x ^= frame_bytes[i];
        if (frame_bytes[0] != hdr_reg || x != frame_bytes[FRAME_BYTES-1]) begin
            n_err++;
            owed.push_back(frame_result(KIND_VERDICT, VERDICT_ERROR, 8'h00, 1'b1));
        end else if (keep_seq != 0 && keep_seq == frame_field(2)) begin
            // repeated sequence number: treated as a check, stored frame untouched
            owe_reply();
        end else begin
            keep_len  = frame_field(1);
            keep_seq  = frame_field(2);
            keep_type = frame_field(3);
            keep_col  = frame_field(4);
            keep_d1   = frame_field(5);
            keep_d2   = frame_field(6);
            if (keep_type == dispense_reg) begin
                n_disp++;
                owed.push_back(frame_result(KIND_VERDICT, VERDICT_DISPENSE, 8'h00, 1'b1));
            end else begin
                owe_reply();
            end
        end
    endtask

    task automatic frame_step(input t_in_item it);
        if (it.operation == OP_TICK) begin
            if (rx_count != 0) begin
                if (ticks_left <= 8'd1) begin
                    ticks_left = '0;
                    rx_count   = 0;
                    n_err++;
                    owed.push_back(frame_result(KIND_VERDICT, VERDICT_ERROR, 8'h00, 1'b1));
                end else begin
                    ticks_left = ticks_left - 8'd1;
                end
            end
        end else begin
            if (rx_count == 0) ticks_left = timeout_reg;
            frame_bytes[rx_count] = it.rx_byte;
            rx_count++;
            if (rx_count >= FRAME_BYTES) begin
                rx_count   = 0;
                ticks_left = '0;
                close_frame();
            end
        end
    endtask

    function automatic string show(input t_out_item o);
        return $sformatf("kind=%0d verdict=%0d len=%02h seq=%02h type=%02h col=%02h d1=%02h d2=%02h byte=%02h last=%0d",
                         o.kind, o.verdict, o.frame_length, o.sequence_res, o.msg_type,
                         o.column, o.data_one, o.data_two, o.reply_byte, o.last);
    endfunction

    // input side
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else if (push && full) begin
            full_stalls++;
        end else begin
            if (push) frame_step(i_in_item);
            if (link_bytes.size() != 0 && (steady || $urandom_range(99) >= 35)) begin
                push      <= 1'b1;
                i_in_item <= link_bytes.pop_front();
            end else begin
                push <= 1'b0;
            end
        end
    end

    // result side
    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                checked++;
                if (owed.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected result: %s", show(o_out_item));
                end else begin
                    want = owed.pop_front();
                    if (o_out_item !== want) begin
                        errors++;
                        if (errors <= 10) begin
                            $display("mismatch on result %0d", checked);
                            $display("  expected %s", show(want));
                            $display("  actual   %s", show(o_out_item));
                        end
                    end
                end
            end
            if (hold_armed && !hold_done) begin
                // long receiver hold so the job queue backs up into full
                hold_cnt++;
                if (hold_cnt >= HOLD_CYCLES) hold_done = 1'b1;
                pop <= 1'b0;
            end else begin
                pop <= steady || ($urandom_range(99) >= 35);
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles, owed.size());
            $display("FAIL vend_channel_frame_handler_core");
            $finish;
        end
    end

    function automatic logic [7:0] rnd_byte();
        int r;
        r = $urandom_range(99);
        if (r < 15) return 8'h00;
        if (r < 30) return 8'hFF;
        return 8'($urandom_range(255));
    endfunction

    task automatic queue_byte(input logic [7:0] b);
        t_in_item it;
        it.operation = OP_BYTE;
        it.rx_byte   = b;
        link_bytes.push_back(it);
        item_total++;
    endtask

    // idle ticks (no frame open) are not counted
    task automatic queue_tick(input bit counted);
        t_in_item it;
        it.operation = OP_TICK;
        it.rx_byte   = 8'($urandom_range(255));
        link_bytes.push_back(it);
        if (counted) item_total++;
    endtask

    task automatic queue_frame(input logic [7:0] hdr, len, seq, typ, col, d1, d2,
                               input bit bad_sum, input int n_ticks);
        logic [7:0] f [0:FRAME_BYTES-1];
        int         tick_at [0:FRAME_BYTES-1];
        logic [7:0] x;
        int         i;
        f[0] = hdr;
        f[1] = len;
        f[2] = seq;
        f[3] = typ;
        f[4] = col;
        f[5] = d1;
        f[6] = d2;
        x = '0;
        for (i = 0; i < FRAME_BYTES - 1; i++) x ^= f[i];
        f[FRAME_BYTES-1] = bad_sum ? x ^ 8'($urandom_range(1, 255)) : x;
        for (i = 0; i < FRAME_BYTES; i++) tick_at[i] = 0;
        repeat (n_ticks) tick_at[$urandom_range(1, FRAME_BYTES - 1)]++;
        for (i = 0; i < FRAME_BYTES; i++) begin
            repeat (tick_at[i]) queue_tick(1'b1);
            queue_byte(f[i]);
        end
    endtask

    // partial frame followed by enough ticks to expire it
    task automatic queue_dropout(input int n_bytes);
        repeat (n_bytes) queue_byte(rnd_byte());
        repeat ((timeout_reg == 0) ? 1 : int'(timeout_reg)) queue_tick(1'b1);
    endtask

    function automatic logic [7:0] pick_seq();
        int r;
        r = $urandom_range(99);
        if (r < 30 && gen_seq != 0) return gen_seq;
        if (r < 40) return 8'h00;
        return rnd_byte();
    endfunction

    task automatic run_phase(input int target);
        int         start, prev_total, r, n, allowed;
        logic [7:0] s, t;
        start = mix_items;
        while (mix_items - start < target) begin
            prev_total = item_total;
            r          = $urandom_range(99);
            allowed    = (timeout_reg == 0) ? 0 : int'(timeout_reg) - 1;
            if (allowed > 3) allowed = 3;
            if (r < 60) begin
                s = pick_seq();
                t = ($urandom_range(99) < 35) ? dispense_reg : rnd_byte();
                n = ($urandom_range(99) < 30) ? $urandom_range(0, allowed) : 0;
                queue_frame(hdr_reg, rnd_byte(), s, t, rnd_byte(), rnd_byte(), rnd_byte(),
                            1'b0, n);
                gen_seq = s;
            end else if (r < 70) begin
                queue_frame(hdr_reg, rnd_byte(), pick_seq(), rnd_byte(), rnd_byte(),
                            rnd_byte(), rnd_byte(), 1'b1, 0);
            end else if (r < 78) begin
                queue_frame(hdr_reg ^ 8'($urandom_range(1, 255)), rnd_byte(), pick_seq(),
                            rnd_byte(), rnd_byte(), rnd_byte(), rnd_byte(), 1'b0, 0);
            end else if (r < 86 && timeout_reg <= 40) begin
                queue_dropout($urandom_range(1, FRAME_BYTES - 1));
            end else if (r < 93) begin
                repeat ($urandom_range(1, 3)) queue_tick(1'b0);
            end else begin
                // line noise, then resync by letting the leftover partial frame expire
                n = (timeout_reg <= 40) ? $urandom_range(1, 12) : FRAME_BYTES;
                repeat (n) queue_byte(8'($urandom_range(255)));
                if (n % FRAME_BYTES != 0) queue_dropout(0);
            end
            mix_items += item_total - prev_total;
        end
    endtask

    task automatic set_reg(input t_cfg_idx idx, input logic [7:0] v);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= v;
        case (idx)
            CFG_HEADER:   hdr_reg      = v;
            CFG_TIMEOUT:  timeout_reg  = v;
            CFG_DISPENSE: dispense_reg = v;
            CFG_STATUS:   status_reg   = v;
            default: ;
        endcase
    endtask

    task automatic load_regs(input logic [7:0] hdr, tmo, disp, stat);
        set_reg(CFG_HEADER, hdr);
        set_reg(CFG_TIMEOUT, tmo);
        set_reg(CFG_DISPENSE, disp);
        set_reg(CFG_STATUS, stat);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        settings++;
    endtask

    // sender stays quiet until every owed result is back, then a short settle
    task automatic drain();
        while (link_bytes.size() != 0 || push || owed.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: idle tick, dispense, repeated sequence, bad checksum
        queue_tick(1'b0);
        queue_frame(8'hED, 8'hFF, 8'h05, 8'h70, 8'h00, 8'hFF, 8'h00, 1'b0, 0);
        queue_frame(8'hED, 8'h00, 8'h05, 8'h33, 8'hFF, 8'h00, 8'hFF, 1'b0, 0);
        queue_frame(8'hED, 8'h12, 8'h00, 8'h00, 8'h34, 8'h56, 8'h78, 1'b1, 0);
        gen_seq = 8'h05;
        run_phase(35);
        drain();

        // reply header wraps, shortest timeout
        load_regs(8'hFF, 8'd1, 8'h00, 8'hFF);
        queue_dropout(3);
        run_phase(55);
        drain();

        // longest timeout, no idling on either side
        steady = 1'b1;
        load_regs(8'h00, 8'd255, 8'hFF, 8'h00);
        run_phase(55);
        drain();
        steady = 1'b0;

        // zero timeout behaves as one; receiver holds off while input keeps coming
        load_regs(rnd_byte(), 8'd0, rnd_byte(), rnd_byte());
        hold_armed = 1'b1;
        queue_dropout(1);
        run_phase(55);
        drain();

        while (item_total < 360) begin
            load_regs(rnd_byte(), 8'($urandom_range(1, 40)), rnd_byte(), rnd_byte());
            queue_dropout($urandom_range(1, FRAME_BYTES - 1));
            run_phase(380 - item_total);
            drain();
        end

        $display("%0d inputs under %0d register settings: %0d dispense, %0d check, %0d error verdicts",
                 item_total, settings, n_disp, n_chk, n_err);
        $display("%0d results checked, input held by full on %0d cycles, %0d mismatches",
                 checked, full_stalls, errors);
        if (errors == 0)
            $display("PASS vend_channel_frame_handler_core");
        else
            $display("FAIL vend_channel_frame_handler_core");
        $finish;
    end

endmodule
